// File: sv/tepb_pkg.sv
// shared types and constants for the tensor element to pixel byte converter
// no dependencies
package tepb_pkg;

  typedef enum logic [1:0] {
    ELEM_HALF   = 2'd0,
    ELEM_SINGLE = 2'd1,
    ELEM_BYTE   = 2'd2
  } elem_type_e;

  localparam logic CFG_ELEMENT_TYPE = 1'b0;
  localparam logic CFG_NORMALIZED   = 1'b1;

  localparam logic [1:0] ELEMENT_TYPE_RST = 2'd0;
  localparam logic       NORMALIZED_RST   = 1'b1;

  // rounded single value heading into the fixed-point round stage
  typedef struct packed {
    logic        valid;
    logic        direct;  // byte already known
    logic [7:0]  dbyte;
    logic [23:0] mant;    // significand with hidden bit
    logic [3:0]  ex;      // unbiased exponent plus two, 0..9
  } rnd_in_t;

endpackage

// File: sv/tensor_element_to_pixel_byte.sv
// tensor element to pixel byte: five-stage pipeline, one word per cycle while not stalled
// stages 1 to 3 are registered here, stages 4 and 5 in tepb_round; stage 5 drives the output
// the whole pipeline advances when the output register is empty or taken
// reset clears valid bits and loads element_type 0 (binary16) and normalized 1
// depends on tepb_pkg and tepb_round
module tensor_element_to_pixel_byte (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [1:0]  cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // element_bits[31:0]
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // pixel_byte[7:0]
);

  logic [1:0] elem_type_q;
  logic       normalized_q;
  logic       en;

  // stage 1: unpacked single
  logic        v1_q;
  logic        byp1_q, zero1_q, sat1_q, scale1_q;
  logic [7:0]  byte1_q, exp1_q;
  logic [23:0] man1_q;
  logic        byp1_d, zero1_d, sat1_d;
  logic [7:0]  exp1_d;
  logic [23:0] man1_d;

  // stage 2: product by 255, or the plain significand when unscaled
  logic        v2_q;
  logic        byp2_q, zero2_q, sat2_q, scale2_q;
  logic [7:0]  byte2_q, exp2_q;
  logic [31:0] prod2_q, prod2_d;

  // stage 3: rounded single, classified
  tepb_pkg::rnd_in_t s3_q, s3_d;

  assign cfg_ready_o   = 1'b1;
  // stall only when the output register holds a word not yet taken
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_type_q  <= tepb_pkg::ELEMENT_TYPE_RST;
      normalized_q <= tepb_pkg::NORMALIZED_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tepb_pkg::CFG_ELEMENT_TYPE: elem_type_q  <= cfg_data_i;
        tepb_pkg::CFG_NORMALIZED:   normalized_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // decode: half widens to single; half subnormals end up below one quarter
  // after scaling, so they are treated as zero
  always_comb begin
    logic       sign;
    logic [4:0] he;
    sign   = 1'b0;
    he     = s_axis_tdata[14:10];
    exp1_d = 8'd0;
    man1_d = 24'd0;
    byp1_d = 1'b0;
    case (tepb_pkg::elem_type_e'(elem_type_q))
      tepb_pkg::ELEM_HALF: begin
        sign = s_axis_tdata[15];
        if (he == 5'd0)       exp1_d = 8'd0;
        else if (he == 5'h1f) exp1_d = 8'hff;
        else                  exp1_d = {3'b0, he} + 8'd112;
        man1_d = {he != 5'd0, s_axis_tdata[9:0], 13'b0};
      end
      tepb_pkg::ELEM_SINGLE: begin
        sign   = s_axis_tdata[31];
        exp1_d = s_axis_tdata[30:23];
        man1_d = {s_axis_tdata[30:23] != 8'd0, s_axis_tdata[22:0]};
      end
      default: byp1_d = 1'b1;
    endcase
    // negative, nan, zero and subnormal all give zero
    zero1_d = sign || exp1_d == 8'd0 || (exp1_d == 8'hff && man1_d[22:0] != 23'd0);
    sat1_d  = !sign && exp1_d == 8'hff && man1_d[22:0] == 23'd0;
  end

  assign prod2_d = scale1_q ? {8'b0, man1_q} * 32'd255 : {8'b0, man1_q};

  // normalize and round the product, then sort out clamp cases
  always_comb begin
    logic [23:0] mant;
    logic [24:0] mr;
    logic        g, st;
    logic signed [9:0] es;
    if (scale2_q) begin
      if (prod2_q[31]) begin
        mant = prod2_q[31:8]; g = prod2_q[7]; st = |prod2_q[6:0];
        es   = $signed({2'b0, exp2_q}) - 10'sd119;
      end else begin
        mant = prod2_q[30:7]; g = prod2_q[6]; st = |prod2_q[5:0];
        es   = $signed({2'b0, exp2_q}) - 10'sd120;
      end
    end else begin
      mant = prod2_q[23:0]; g = 1'b0; st = 1'b0;
      es   = $signed({2'b0, exp2_q}) - 10'sd127;
    end
    mr = {1'b0, mant} + {24'b0, g & (st | mant[0])};
    if (mr[24]) begin
      mant = mr[24:1];
      es   = es + 10'sd1;
    end else begin
      mant = mr[23:0];
    end
    s3_d.valid  = v2_q;
    s3_d.mant   = mant;
    s3_d.ex     = 4'(es + 10'sd2);
    s3_d.direct = 1'b1;
    if (byp2_q)                                  s3_d.dbyte = byte2_q;
    else if (zero2_q)                            s3_d.dbyte = 8'd0;
    else if (sat2_q || es > 10'sd7)              s3_d.dbyte = 8'hff;
    else if (es == 10'sd7 && mant >= 24'hff0000) s3_d.dbyte = 8'hff;
    else if (es < -10'sd2)                       s3_d.dbyte = 8'd0;
    else begin
      s3_d.dbyte  = 8'd0;
      s3_d.direct = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      s3_q.valid <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      s3_q <= s3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      byp1_q      <= byp1_d;
      zero1_q     <= zero1_d;
      sat1_q      <= sat1_d;
      scale1_q    <= normalized_q;
      byte1_q     <= s_axis_tdata[7:0];
      exp1_q      <= exp1_d;
      man1_q      <= man1_d;
      byp2_q      <= byp1_q;
      zero2_q     <= zero1_q;
      sat2_q      <= sat1_q;
      scale2_q    <= scale1_q;
      byte2_q     <= byte1_q;
      exp2_q      <= exp1_q;
      prod2_q     <= prod2_d;
    end
  end

  tepb_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .in_i    (s3_q),
    .valid_o (m_axis_tvalid),
    .byte_o  (m_axis_tdata)
  );

endmodule

// File: sv/tepb_round.sv
// adds one half in single precision and truncates to a byte, two stages
// depends on tepb_pkg
module tepb_round (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  tepb_pkg::rnd_in_t in_i,
  output logic             valid_o,
  output logic [7:0]       byte_o
);

  logic        v4_q;
  logic        dir4_q;
  logic [7:0]  db4_q;
  logic [33:0] t4_q, t4_d;
  logic [3:0]  sh4_q, sh4_d;
  logic        v5_q;
  logic [7:0]  b5_q, b5_d;

  // fixed point with 25 fraction bits, exact for values of one quarter and up
  always_comb begin
    logic [32:0] fixed;
    fixed = {9'b0, in_i.mant} << in_i.ex;
    t4_d  = {1'b0, fixed} + (34'd1 << 24);
    sh4_d = 4'd1;
    for (int i = 24; i <= 32; i++) begin
      if (t4_d[i]) sh4_d = 4'(i - 23);
    end
  end

  // round to 24 significant bits, nearest even
  always_comb begin
    logic [33:0] q, r, below;
    logic        g, st;
    q     = t4_q >> sh4_q;
    g     = t4_q[5'(sh4_q - 4'd1)];
    below = (34'd1 << (sh4_q - 4'd1)) - 34'd1;
    st    = |(t4_q & below);
    q     = q + {33'b0, g & (st | q[0])};
    r     = q << sh4_q;
    b5_d  = dir4_q ? db4_q : r[32:25];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= in_i.valid;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dir4_q <= in_i.direct;
      db4_q  <= in_i.dbyte;
      t4_q   <= t4_d;
      sh4_q  <= sh4_d;
      b5_q   <= b5_d;
    end
  end

  assign valid_o = v5_q;
  assign byte_o  = b5_q;

endmodule

// File: tb/sv/tb_top.sv
// testbench for the tensor element to pixel byte converter: directed and random element words,
// a bit-exact integer model of the float conversion, and checks of every output word in order
// depends on tepb_pkg and tensor_element_to_pixel_byte
module tb_top;

  // selector code outside the enum, handled as byte passthrough
  localparam logic [1:0] ELEM_SPARE = 2'd3;
  localparam int QUIET_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum logic [1:0] {
    ACT_ELEM,
    ACT_CFG,
    ACT_DRAIN
  } act_e;

  typedef struct {
    act_e        act;
    logic [31:0] bits;
    logic        idx;
    logic [1:0]  val;
  } pend_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [1:0]  cfg_data_i = 2'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = 32'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  tensor_element_to_pixel_byte u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  pend_t      pend_q[$];
  logic [7:0] pixel_q[$];
  int         n_sent = 0;
  int         n_got = 0;
  int         errors = 0;
  int         cycles = 0;

  // shadow copy of the configuration registers
  logic [1:0] cur_type = tepb_pkg::ELEMENT_TYPE_RST;
  logic       cur_norm = tepb_pkg::NORMALIZED_RST;

  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    $display("mismatch %s: expected %0d got %0d (word %0d)", what, want, got, n_got);
    errors++;
  endtask

  task automatic add_pend(pend_t p);
    pend_q.insert(pend_q.size(), p);
  endtask

  function automatic int msb_of(logic [127:0] v);
    int m;
    m = -1;
    for (int i = 0; i < 128; i++)
      if (v[i]) m = i;
    return m;
  endfunction

  // round v to 24 significant bits, nearest even; exponent adjusted in place
  function automatic logic [127:0] round24(logic [127:0] v, inout int e);
    int sh;
    logic [127:0] keep, rem, halfv;
    sh = msb_of(v) - 23;
    if (sh <= 0) return v;
    keep  = v >> sh;
    rem   = v & ((128'd1 << sh) - 128'd1);
    halfv = 128'd1 << (sh - 1);
    if (rem > halfv || (rem == halfv && keep[0])) keep = keep + 128'd1;
    e = e + sh;
    if (keep[24]) begin
      keep = keep >> 1;
      e = e + 1;
    end
    return keep;
  endfunction

  function automatic logic [31:0] half_to_single(logic [15:0] h);
    logic [4:0] ex;
    logic [9:0] man;
    int e;
    ex  = h[14:10];
    man = h[9:0];
    if (ex == 5'd0) begin
      if (man == 10'd0) return {h[15], 31'd0};
      // normalize the subnormal
      e = 113;
      while (!man[9]) begin
        man = man << 1;
        e--;
      end
      man = man << 1;
      return {h[15], 8'(e - 1), man, 13'd0};
    end
    if (ex == 5'd31) return {h[15], 8'hff, h[9:0], 13'd0};
    return {h[15], 8'(ex + 112), h[9:0], 13'd0};
  endfunction

  // single value to byte: optional scale by 255, clamp, add one half, truncate
  function automatic logic [7:0] float_to_pixel(logic [31:0] f, logic scale);
    logic [7:0]  ex;
    logic [22:0] fr;
    logic [127:0] x, t;
    int e, pos, ep;
    ex = f[30:23];
    fr = f[22:0];
    if (ex == 8'hff && fr != 23'd0) return 8'd0;  // nan
    if (f[31]) return 8'd0;                      // negatives and minus zero
    if (ex == 8'hff) return 8'd255;
    if (ex == 8'd0 && fr == 23'd0) return 8'd0;
    if (ex == 8'd0) begin
      x = 128'(fr);
      e = -149;
    end else begin
      x = 128'({1'b1, fr});
      e = int'(ex) - 150;
    end
    if (scale) x = round24(x * 128'd255, e);
    pos = msb_of(x) + e;
    if (pos >= 8) return 8'd255;
    if (pos < -40) return 8'd0;
    // exact fixed point with 80 fraction bits, then add one half and round to single
    t = (x << (e + 80)) + (128'd1 << 79);
    ep = 0;
    t = round24(t, ep);
    t = t << ep;
    if ((t >> 80) > 128'd255) return 8'd255;
    return t[87:80];
  endfunction

  function automatic logic [7:0] predict_pixel(logic [31:0] bits);
    case (cur_type)
      tepb_pkg::ELEM_HALF:   return float_to_pixel(half_to_single(bits[15:0]), cur_norm);
      tepb_pkg::ELEM_SINGLE: return float_to_pixel(bits, cur_norm);
      default:               return bits[7:0];
    endcase
  endfunction

  // ---------------------------------------------------------------- driver
  int tx_gap = 0;
  int quiet = 0;

  always @(posedge clk_i) begin
    logic busy;
    logic ready_now;
    logic nxt_valid;
    logic nxt_cfg;
    pend_t p;
    if (rst_ni) begin
      busy = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        pixel_q.insert(pixel_q.size(), predict_pixel(s_axis_tdata));
        n_sent++;
      end else if (s_axis_tvalid) begin
        busy = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == tepb_pkg::CFG_ELEMENT_TYPE) cur_type = cfg_data_i;
        else cur_norm = cfg_data_i[0];
      end else if (cfg_valid_i) begin
        busy = 1'b1;
      end
      // block is idle once every word is back and quiet has reached QUIET_CYCLES
      if (n_sent == n_got && !s_axis_tvalid) quiet++;
      else quiet = 0;
      if (!busy) begin
        nxt_valid = 1'b0;
        nxt_cfg   = 1'b0;
        ready_now = quiet >= QUIET_CYCLES;
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pend_q.size() > 0) begin
          p = pend_q[0];
          if (p.act == ACT_ELEM) begin
            void'(pend_q.pop_front());
            nxt_valid = 1'b1;
            s_axis_tdata <= p.bits;
            if (pend_q.size() > 60 && $urandom_range(0, 7) == 0)
              tx_gap = $urandom_range(1, 19);
          end else if (ready_now) begin
            void'(pend_q.pop_front());
            if (p.act == ACT_CFG) begin
              nxt_cfg = 1'b1;
              cfg_index_i <= p.idx;
              cfg_data_i  <= p.val;
            end
          end
        end
        s_axis_tvalid <= nxt_valid;
        cfg_valid_i   <= nxt_cfg;
      end
    end
  end

  // --------------------------------------------------------------- monitor
  int rx_stall = 0;

  always @(posedge clk_i) begin
    logic [7:0] want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixel_q.size() == 0) begin
          report_mismatch("unexpected pixel_byte", 8'd0, m_axis_tdata);
        end else begin
          want = pixel_q.pop_front();
          if (m_axis_tdata !== want) report_mismatch("pixel_byte", want, m_axis_tdata);
        end
        n_got++;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (pend_q.size() > 60 && $urandom_range(0, 9) == 0)
          rx_stall = $urandom_range(1, 19);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // -------------------------------------------------------------- stimulus
  function automatic pend_t elem(logic [31:0] bits);
    pend_t p;
    p.act = ACT_ELEM;
    p.bits = bits;
    p.idx = 1'b0;
    p.val = 2'd0;
    return p;
  endfunction

  function automatic pend_t cfg(logic idx, logic [1:0] val);
    pend_t p;
    p.act = ACT_CFG;
    p.bits = 32'd0;
    p.idx = idx;
    p.val = val;
    return p;
  endfunction

  // mix of raw words and floats near the interesting range
  function automatic logic [31:0] rand_elem();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 3))
      0: ;
      1: r[14:10] = 5'($urandom_range(8, 22));
      2: r[30:23] = 8'($urandom_range(110, 136));
      default: if ($urandom_range(0, 1)) r[30:23] = 8'($urandom_range(0, 2)) * 8'd127;
    endcase
    return r;
  endfunction

  initial begin
    pend_t dr;
    // binary16 with scaling, the reset setting: zeros, one, half, infinities, nan,
    // subnormals, and upper bits that must be ignored
    add_pend(elem(32'h0000_0000));
    add_pend(elem(32'h0000_8000));
    add_pend(elem(32'h0000_3c00));
    add_pend(elem(32'h0000_7c00));
    add_pend(elem(32'h0000_fc00));
    add_pend(elem(32'h0000_7e01));
    add_pend(elem(32'h0000_0001));
    add_pend(elem(32'h0000_03ff));
    add_pend(elem(32'hffff_3800));
    // binary32 with scaling: overflow of the product, nan, tiny, negative
    add_pend(cfg(tepb_pkg::CFG_ELEMENT_TYPE, tepb_pkg::ELEM_SINGLE));
    add_pend(elem(32'h7f7f_ffff));
    add_pend(elem(32'h7fc0_0000));
    add_pend(elem(32'h0000_0001));
    add_pend(elem(32'hbf80_0000));
    // unscaled: value just below one half rounds up, 255 and above clamp
    add_pend(cfg(tepb_pkg::CFG_NORMALIZED, 2'd0));
    add_pend(elem(32'h3eff_ffff));
    add_pend(elem(32'h437f_0000));
    add_pend(elem(32'h437f_8000));
    add_pend(elem(32'hff80_0000));
    add_pend(cfg(tepb_pkg::CFG_ELEMENT_TYPE, tepb_pkg::ELEM_HALF));
    add_pend(elem(32'h0000_7bff));
    add_pend(elem(32'h0000_57f8));
    // byte passthrough and the spare selector
    add_pend(cfg(tepb_pkg::CFG_ELEMENT_TYPE, tepb_pkg::ELEM_BYTE));
    add_pend(elem(32'hffff_ffff));
    add_pend(cfg(tepb_pkg::CFG_ELEMENT_TYPE, ELEM_SPARE));
    add_pend(elem(32'h1234_5600));
    // random phases, each with its own setting
    for (int ph = 0; ph < 11; ph++) begin
      add_pend(cfg(tepb_pkg::CFG_ELEMENT_TYPE, 2'($urandom_range(0, 3))));
      add_pend(cfg(tepb_pkg::CFG_NORMALIZED, 2'($urandom_range(0, 1))));
      for (int k = 0; k < 48; k++) begin
        if (ph == 5 && k == 24) begin
          dr = elem(32'd0);
          dr.act = ACT_DRAIN;
          add_pend(dr);
        end
        add_pend(elem(rand_elem()));
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pend_q.size() > 0 || s_axis_tvalid || n_got != n_sent) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/tepb_pkg.sv
sv/tepb_round.sv
sv/tensor_element_to_pixel_byte.sv
tb/sv/tb_top.sv
